[hdl/adaptive_drop_event_detector_core_defines.svh]
// assertion macros shared by the detector modules
`ifndef ADAPTIVE_DROP_EVENT_DETECTOR_CORE_DEFINES_SVH
`define ADAPTIVE_DROP_EVENT_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked out of reset
`define ADET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// property checked on every edge, reset included
`define ADET_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ADET_ASSERT(label, prop, msg)
`define ADET_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hdl/adet_pkg.sv]
package adet_pkg;

    // fixed field widths
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 19;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // defaults
    localparam int CALIB_SAMPLES_DEFAULT = 5;
    localparam logic [COUNT_W-1:0] SENS_RESET = 16'd200;

    // register word index (paddr[2])
    localparam logic REG_SENSITIVITY = 1'b0;

    typedef enum logic [1:0] {
        MODE_CALIB = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_EVENT = 2'd2
    } mode_t;

    // one result transaction
    typedef struct packed {
        logic [COUNT_W-1:0] count_echo;
        logic               start_event;
        logic               end_event;
        logic [COUNT_W-1:0] event_seconds;
        logic               calibrating;
        logic               in_event;
        logic [COUNT_W-1:0] start_threshold;
        logic [COUNT_W-1:0] end_threshold;
    } result_t;

    // a - b, floored at zero
    function automatic logic [COUNT_W-1:0] sat_sub(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    // a + b, clamped at full scale
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
    endfunction

endpackage

[hdl/adet_obuf.sv]
`include "adaptive_drop_event_detector_core_defines.svh"

module adet_obuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  adet_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output adet_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    adet_pkg::result_t out_data_reg, out_data_next;
    adet_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;
    logic              push;

    assign pop       = out_valid_reg && out_ready;
    assign push      = in_valid && !skid_valid_reg;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // two-entry buffer: output register plus skid register
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ADET_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid full while output empty")
    `ADET_ASSERT(a_skid_drains, (pop && skid_valid_reg) |=> out_valid_reg, "output emptied with skid pending")
    `ADET_ASSERT(a_full_holds, (skid_valid_reg && !out_ready) |=> skid_valid_reg, "skid lost while stalled")

endmodule

[hdl/adaptive_drop_event_detector_core.sv]
// each result is computed combinationally and registered in the output buffer when its input is accepted
// throughput: one transaction per cycle while the output buffer is not full; all work is one registered pass
// a two-entry output buffer keeps the input open while one result is stalled
// reset (aresetn low, synchronous): calibration mode, all state zero,
// sensitivity 200, output buffer empty
`include "adaptive_drop_event_detector_core_defines.svh"

module adaptive_drop_event_detector_core #(
    parameter int CALIB_SAMPLES = adet_pkg::CALIB_SAMPLES_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // apb configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adet_pkg::APB_AW-1:0]  paddr,
    input  logic [adet_pkg::APB_DW-1:0]  pwdata,
    output logic [adet_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [adet_pkg::COUNT_W-1:0] s_count,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [adet_pkg::COUNT_W-1:0] m_count_echo,
    output logic                         m_start_event,
    output logic                         m_end_event,
    output logic [adet_pkg::COUNT_W-1:0] m_event_seconds,
    output logic                         m_calibrating,
    output logic                         m_in_event,
    output logic [adet_pkg::COUNT_W-1:0] m_start_threshold,
    output logic [adet_pkg::COUNT_W-1:0] m_end_threshold
);

    localparam int CW      = adet_pkg::COUNT_W;
    localparam int SW      = adet_pkg::SUM_W;
    localparam int TAKEN_W = $clog2(CALIB_SAMPLES + 1);
    // floor(sum / CALIB_SAMPLES) as multiply by rounded-up reciprocal
    localparam int RECIP_SHIFT = SW + 3;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);
    localparam logic [TAKEN_W-1:0] SAMPLES = TAKEN_W'(CALIB_SAMPLES);

    adet_pkg::mode_t    mode_reg, mode_next;
    logic [SW-1:0]      calib_sum_reg, calib_sum_next;
    logic [TAKEN_W-1:0] calib_taken_reg, calib_taken_next;
    logic [CW-1:0]      baseline_reg, baseline_next;
    logic [CW-1:0]      minimum_reg, minimum_next;
    logic [CW-1:0]      start_level_reg, start_level_next;
    logic [CW-1:0]      end_level_reg, end_level_next;
    logic [CW-1:0]      event_ticks_reg, event_ticks_next;
    logic [CW-1:0]      sensitivity_reg, sensitivity_next;

    logic                 accept;
    logic                 started;
    logic                 ended;
    logic [CW-1:0]        seconds;
    logic [SW+RECIP_W-1:0] quot_prod;
    logic [CW:0]          base_sum;
    adet_pkg::result_t    result;
    adet_pkg::result_t    m_data;
    logic                 cfg_write;

    assign accept = s_valid && s_ready;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == adet_pkg::REG_SENSITIVITY) ?
                       {{(adet_pkg::APB_DW-CW){1'b0}}, sensitivity_reg} : '0;

    always_comb begin
        sensitivity_next = sensitivity_reg;
        if (cfg_write && paddr[2] == adet_pkg::REG_SENSITIVITY) begin
            sensitivity_next = pwdata[CW-1:0];
        end
    end

    // per-transaction mode update
    always_comb begin
        mode_next        = mode_reg;
        calib_sum_next   = calib_sum_reg;
        calib_taken_next = calib_taken_reg;
        baseline_next    = baseline_reg;
        minimum_next     = minimum_reg;
        start_level_next = start_level_reg;
        end_level_next   = end_level_reg;
        event_ticks_next = event_ticks_reg;
        started          = 1'b0;
        ended            = 1'b0;
        seconds          = '0;
        quot_prod        = '0;
        base_sum         = '0;
        case (mode_reg)
            adet_pkg::MODE_CALIB: begin
                calib_sum_next   = calib_sum_reg + {{(SW-CW){1'b0}}, s_count};
                calib_taken_next = calib_taken_reg + 1'b1;
                if (calib_taken_next >= SAMPLES) begin
                    quot_prod = {{RECIP_W{1'b0}}, calib_sum_next} *
                                {{SW{1'b0}}, RECIP};
                    baseline_next    = quot_prod[RECIP_SHIFT +: CW];
                    start_level_next = adet_pkg::sat_sub(baseline_next, sensitivity_reg);
                    mode_next        = adet_pkg::MODE_IDLE;
                end
            end
            adet_pkg::MODE_EVENT: begin
                minimum_next   = (s_count < minimum_reg) ? s_count : minimum_reg;
                end_level_next = adet_pkg::sat_add(minimum_next, sensitivity_reg);
                if (event_ticks_reg != '1) begin
                    event_ticks_next = event_ticks_reg + 1'b1;
                end
                if (s_count > end_level_next) begin
                    ended            = 1'b1;
                    seconds          = event_ticks_next;
                    start_level_next = adet_pkg::sat_sub(end_level_next, sensitivity_reg);
                    baseline_next    = start_level_next;
                    mode_next        = adet_pkg::MODE_IDLE;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                if (s_count < start_level_reg) begin
                    minimum_next     = s_count;
                    event_ticks_next = '0;
                    started          = 1'b1;
                    mode_next        = adet_pkg::MODE_EVENT;
                end else begin
                    base_sum         = {1'b0, baseline_reg} + {1'b0, s_count};
                    baseline_next    = base_sum[CW:1];
                    start_level_next = adet_pkg::sat_sub(baseline_next, sensitivity_reg);
                end
            end
        endcase
    end

    // result of this transaction
    always_comb begin
        result.count_echo      = s_count;
        result.start_event     = started;
        result.end_event       = ended;
        result.event_seconds   = seconds;
        result.calibrating     = (mode_next == adet_pkg::MODE_CALIB);
        result.in_event        = (mode_next == adet_pkg::MODE_EVENT);
        result.start_threshold = start_level_next;
        result.end_threshold   = end_level_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= adet_pkg::MODE_CALIB;
            calib_sum_reg   <= '0;
            calib_taken_reg <= '0;
            baseline_reg    <= '0;
            minimum_reg     <= '0;
            start_level_reg <= '0;
            end_level_reg   <= '0;
            event_ticks_reg <= '0;
            sensitivity_reg <= adet_pkg::SENS_RESET;
        end else begin
            sensitivity_reg <= sensitivity_next;
            if (accept) begin
                mode_reg        <= mode_next;
                calib_sum_reg   <= calib_sum_next;
                calib_taken_reg <= calib_taken_next;
                baseline_reg    <= baseline_next;
                minimum_reg     <= minimum_next;
                start_level_reg <= start_level_next;
                end_level_reg   <= end_level_next;
                event_ticks_reg <= event_ticks_next;
            end
        end
    end

    // result buffer
    adet_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign m_count_echo      = m_data.count_echo;
    assign m_start_event     = m_data.start_event;
    assign m_end_event       = m_data.end_event;
    assign m_event_seconds   = m_data.event_seconds;
    assign m_calibrating     = m_data.calibrating;
    assign m_in_event        = m_data.in_event;
    assign m_start_threshold = m_data.start_threshold;
    assign m_end_threshold   = m_data.end_threshold;

    `ADET_ASSERT(a_calib_once, mode_reg != adet_pkg::MODE_CALIB |=> mode_reg != adet_pkg::MODE_CALIB, "returned to calibration")
    `ADET_ASSERT(a_start_enters, (m_valid && m_start_event) |-> (m_in_event && !m_calibrating && !m_end_event), "event start without event mode")
    `ADET_ASSERT(a_end_length, (m_valid && m_end_event) |-> (!m_in_event && m_event_seconds != '0), "event end with bad length")

endmodule
